// ----- rtl/daq_double_buffer_sequencer_unit_assert.svh -----
// Assertion macros shared by the acquisition sequencer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DAQ_DOUBLE_BUFFER_SEQUENCER_UNIT_ASSERT_SVH
`define DAQ_DOUBLE_BUFFER_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, checked out of reset.
`define DBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ----- rtl/dbs_pkg.sv -----
// Types and constants of the acquisition sequencer.
// No dependencies; used by every module of the block.
package dbs_pkg;

  localparam int unsigned RowW  = 17;
  localparam int unsigned TickW = 32;
  localparam int unsigned DivW  = 31;
  localparam int unsigned AddrW = 5;
  localparam int unsigned IdxW  = 3;

  // buffer depth in rows
  localparam logic [RowW-1:0] Rows = RowW'(65536);

  // strobe sources
  localparam logic [1:0] StrobeAdcA  = 2'd0;
  localparam logic [1:0] StrobeAdcB  = 2'd1;
  localparam logic [1:0] StrobeTimer = 2'd2;

  // trigger source selecting the software trigger
  localparam logic [3:0] TrigUser = 4'd8;

  // register indexes
  localparam logic [IdxW-1:0] RegStrobeSelect  = 3'd0;
  localparam logic [IdxW-1:0] RegAdcADivider   = 3'd1;
  localparam logic [IdxW-1:0] RegAdcBDivider   = 3'd2;
  localparam logic [IdxW-1:0] RegStrobePeriod  = 3'd3;
  localparam logic [IdxW-1:0] RegTriggerSelect = 3'd4;
  localparam logic [IdxW-1:0] RegTriggerPeriod = 3'd5;

  typedef struct packed {
    logic [1:0]      strobe_select;
    logic [DivW-1:0] adc_a_divider;
    logic [DivW-1:0] adc_b_divider;
    logic [DivW-1:0] strobe_period;
    logic [3:0]      trigger_select;
    logic [DivW-1:0] trigger_period;
  } cfg_t;

  typedef struct packed {
    logic strobe;
    logic done_a;
    logic done_b;
    logic trig_due;
  } timer_status_t;

  typedef struct packed {
    logic [TickW-1:0] trigger_total;
    logic             buffer_swapped;
    logic             latch_b;
    logic             latch_a;
    logic             row_stored;
    logic [RowW-1:0]  row_index;
    logic             active_buffer;
  } result_t;

endpackage

// ----- rtl/dbs_apb_regs.sv -----
// APB configuration registers of the acquisition sequencer.
// Depends on dbs_pkg.
module dbs_apb_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [dbs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output dbs_pkg::cfg_t            cfg_o
);

  dbs_pkg::cfg_t               cfg_q;
  logic                        wr_en;
  logic [dbs_pkg::IdxW-1:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[dbs_pkg::AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        dbs_pkg::RegStrobeSelect:  cfg_q.strobe_select  <= pwdata[1:0];
        dbs_pkg::RegAdcADivider:   cfg_q.adc_a_divider  <= pwdata[dbs_pkg::DivW-1:0];
        dbs_pkg::RegAdcBDivider:   cfg_q.adc_b_divider  <= pwdata[dbs_pkg::DivW-1:0];
        dbs_pkg::RegStrobePeriod:  cfg_q.strobe_period  <= pwdata[dbs_pkg::DivW-1:0];
        dbs_pkg::RegTriggerSelect: cfg_q.trigger_select <= pwdata[3:0];
        dbs_pkg::RegTriggerPeriod: cfg_q.trigger_period <= pwdata[dbs_pkg::DivW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dbs_pkg::RegStrobeSelect:  prdata = {30'd0, cfg_q.strobe_select};
      dbs_pkg::RegAdcADivider:   prdata = {1'b0, cfg_q.adc_a_divider};
      dbs_pkg::RegAdcBDivider:   prdata = {1'b0, cfg_q.adc_b_divider};
      dbs_pkg::RegStrobePeriod:  prdata = {1'b0, cfg_q.strobe_period};
      dbs_pkg::RegTriggerSelect: prdata = {28'd0, cfg_q.trigger_select};
      dbs_pkg::RegTriggerPeriod: prdata = {1'b0, cfg_q.trigger_period};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/dbs_tick_timers.sv -----
// Elapsed-tick counters for ADC A, ADC B, strobe and trigger timers.
// Depends on dbs_pkg and the assertion macro header.
`include "daq_double_buffer_sequencer_unit_assert.svh"

module dbs_tick_timers (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  en_i,
  input  dbs_pkg::cfg_t         cfg_i,
  input  logic                  fire_i,
  output dbs_pkg::timer_status_t status_o
);

  localparam logic [dbs_pkg::TickW-1:0] TickMax = '1;

  logic                      enable_seen_q;
  logic [dbs_pkg::TickW-1:0] a_q, b_q, s_q, t_q;
  logic [dbs_pkg::TickW-1:0] a_n, b_n, s_n, t_n;
  logic                      rise, done_a, done_b, strobe_due, ready;

  function automatic logic [dbs_pkg::TickW-1:0] sat_inc(
    input logic [dbs_pkg::TickW-1:0] v
  );
    sat_inc = (v == TickMax) ? v : v + 1'b1;
  endfunction

  // a rising enable restarts every timer
  assign rise = !enable_seen_q;
  assign a_n  = rise ? '0 : sat_inc(a_q);
  assign b_n  = rise ? '0 : sat_inc(b_q);
  assign s_n  = rise ? '0 : sat_inc(s_q);
  assign t_n  = rise ? '0 : sat_inc(t_q);

  assign done_a     = a_n >= {1'b0, cfg_i.adc_a_divider};
  assign done_b     = b_n >= {1'b0, cfg_i.adc_b_divider};
  assign strobe_due = s_n >= ({1'b0, cfg_i.strobe_period} + 1'b1);

  always_comb begin
    unique case (cfg_i.strobe_select)
      dbs_pkg::StrobeAdcA:  ready = done_a;
      dbs_pkg::StrobeAdcB:  ready = done_b;
      dbs_pkg::StrobeTimer: ready = strobe_due;
      default:              ready = 1'b0;
    endcase
  end

  assign status_o.strobe   = en_i && ready;
  assign status_o.done_a   = done_a;
  assign status_o.done_b   = done_b;
  assign status_o.trig_due = t_n >= ({1'b0, cfg_i.trigger_period} + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_seen_q <= 1'b0;
      a_q           <= '0;
      b_q           <= '0;
      s_q           <= '0;
      t_q           <= '0;
    end else if (step_i) begin
      if (!en_i) begin
        enable_seen_q <= 1'b0;
      end else begin
        enable_seen_q <= 1'b1;
        a_q <= (status_o.strobe && done_a) ? '0 : a_n;
        b_q <= (status_o.strobe && done_b) ? '0 : b_n;
        s_q <= status_o.strobe ? '0 : s_n;
        t_q <= fire_i ? '0 : t_n;
      end
    end
  end

  `DBS_ASSERT_NEXT(a_rise_clears, step_i && en_i && !enable_seen_q, a_q == '0 && s_q == '0)
  `DBS_ASSERT_IMPL(a_strobe_needs_en, status_o.strobe, en_i)

endmodule

// ----- rtl/dbs_row_seq.sv -----
// Row position, double-buffer select and trigger counting.
// Depends on dbs_pkg and the assertion macro header.
`include "daq_double_buffer_sequencer_unit_assert.svh"

module dbs_row_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   user_trigger_i,
  input  logic [3:0]             trigger_select_i,
  input  dbs_pkg::timer_status_t status_i,
  output logic                   fire_o,
  output dbs_pkg::result_t       result_o
);

  logic [dbs_pkg::RowW-1:0]  pos_q, pos_d;
  logic                      buf_q;
  logic [dbs_pkg::TickW-1:0] cnt_q, cnt_d;
  logic                      pending_q, pending_d, pending_eff, src_fire;
  logic                      user_src;

  assign pending_eff = pending_q || user_trigger_i;
  assign user_src    = trigger_select_i == dbs_pkg::TrigUser;

  always_comb begin
    priority if (user_src) begin
      src_fire = pending_eff;
    end else if (!trigger_select_i[3]) begin
      src_fire = status_i.trig_due;
    end else begin
      src_fire = 1'b0;
    end
  end

  assign fire_o = status_i.strobe && src_fire;

  // consume the software trigger only on a strobe in user mode
  assign pending_d = pending_eff && !(status_i.strobe && user_src);

  always_comb begin
    priority if (fire_o) begin
      pos_d = '0;
    end else if (status_i.strobe && pos_q <= dbs_pkg::Rows) begin
      pos_d = pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  assign cnt_d = fire_o ? cnt_q + 1'b1 : cnt_q;

  assign result_o.active_buffer  = buf_q;
  assign result_o.row_index      = pos_q;
  assign result_o.row_stored     = pos_q < dbs_pkg::Rows;
  assign result_o.latch_a        = status_i.done_a;
  assign result_o.latch_b        = status_i.done_b;
  assign result_o.buffer_swapped = fire_o;
  assign result_o.trigger_total  = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      buf_q     <= 1'b0;
      cnt_q     <= '0;
      pending_q <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      buf_q     <= buf_q ^ fire_o;
      cnt_q     <= cnt_d;
      pending_q <= pending_d;
    end
  end

  `DBS_ASSERT_IMPL(a_pos_clamped, 1'b1, pos_q <= dbs_pkg::Rows + 1'b1)
  `DBS_ASSERT_NEXT(a_fire_swaps, step_i && fire_o, pos_q == '0 && buf_q != $past(buf_q))

endmodule

// ----- rtl/daq_double_buffer_sequencer_unit.sv -----
// Top level of the double-buffered acquisition sequencer.
// Depends on dbs_pkg, dbs_apb_regs, dbs_tick_timers, dbs_row_seq and the assertion header.
//
// Each input beat is one clock tick of the acquisition timing: tdata[0] is the
// enable level, tdata[1] a software trigger pulse. A rising enable restarts the
// ADC A, ADC B, strobe and trigger timers. On every tick that produces a sample
// strobe one output beat reports the active buffer, the row position, whether
// the row lies inside the buffer, which ADCs latched, whether a buffer trigger
// swapped the buffers, and the trigger count after the tick; ticks without a
// strobe produce no beat. Throughput is one tick per clock unless the output
// stalls: a beat is taken into an input register, processed by the timer and
// row logic (32-bit increment and compare per timer), and the result lands in
// an output register.
// Input is stalled only while the output register holds an untaken beat and a
// new tick waits behind it. Write configuration over APB only while idle.
`include "daq_double_buffer_sequencer_unit_assert.svh"

module daq_double_buffer_sequencer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [0] acq_enable, [1] user_trigger
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] active_buffer, [17:1] row_index, [18] row_stored, [19] latch_a,
  // [20] latch_b, [21] buffer_swapped, [53:22] trigger_total
  output logic [55:0]               m_axis_tdata,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dbs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  dbs_pkg::cfg_t          cfg;
  dbs_pkg::timer_status_t status;
  dbs_pkg::result_t       result, res_q;

  logic in_valid_q, in_en_q, in_ut_q;
  logic out_valid_q, out_valid_d;
  logic advance, fire;

  // advance the held tick when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_en_q <= s_axis_tdata[0];
      in_ut_q <= s_axis_tdata[1];
    end
  end

  dbs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dbs_tick_timers u_timers (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .en_i     (in_en_q),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .status_o (status)
  );

  dbs_row_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .user_trigger_i   (in_ut_q),
    .trigger_select_i (cfg.trigger_select),
    .status_i         (status),
    .fire_o           (fire),
    .result_o         (result)
  );

  // load a result on a strobe tick, drop the beat once taken
  always_comb begin
    priority if (advance) begin
      out_valid_d = status.strobe;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && status.strobe) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  `DBS_ASSERT_IMPL(a_stored_flag, out_valid_q, res_q.row_stored == (res_q.row_index < dbs_pkg::Rows))
  `DBS_ASSERT_IMPL(a_swap_resets_row, advance && fire, result.buffer_swapped && status.strobe)

endmodule
